FILE: sv/rgbapr_pkg.sv
// Shared widths, codes and payload types of the RGBA residual predictor.
`timescale 1ns / 1ps

package rgbapr_pkg;

  localparam int S_TDATA_W    = 48;
  localparam int S_TUSER_W    = 2;
  localparam int M_TDATA_W    = 64;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam int ROW_WIDTH_W  = 13;
  localparam int NUM_CHAN     = 4;
  localparam int HIST_BINS    = 256;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = 2;
  localparam int FIFO_CNT_W   = 3;
  localparam int CLR_CNT_W    = 9;

  localparam logic [7:0]             PREV_GREEN_INIT = 8'h80;
  localparam logic [7:0]             PREV_ALPHA_INIT = 8'h80;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 13'd4096;

  // Item kinds carried in tuser bit 0
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Register index, taken from paddr bit 2
  localparam logic REG_GRADIENT  = 1'b0;
  localparam logic REG_ROW_WIDTH = 1'b1;

  typedef struct packed {
    logic [31:0] count_value;
    logic [7:0]  res_alpha;
    logic [7:0]  res_red;
    logic [7:0]  res_blue;
    logic [7:0]  res_green;
  } out_item_t;

endpackage

FILE: sv/rgba_predict_residual_count.sv
// Top level: RGBA left/gradient residual predictor with four residual histograms.
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// s_        tvalid/tready        tdata: green, blue, red, alpha, count_channel, count_index
//                                tuser: cmd, frame_start
// m_        tvalid/tready        tdata: res_green, res_blue, res_red, res_alpha, count_value
// apb       psel/penable/pready  reg 0 gradient_mode at 0x0, reg 1 row_width at 0x4
//
// One item per clock sustained while s_tready is high; a result passes the line store read
// at the transfer edge, the histogram read and the histogram write-back, which also writes
// it into the output FIFO, from which m_ can take it.
// After reset a clearing pass over all 256 bins zeroes the histogram memories; s_tready is low.
// Histogram read-modify-write back to back is covered by forwarding the last write.
// s_tready drops when the 4-entry output FIFO plus in-flight items would fill it.

module rgba_predict_residual_count #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // green[7:0] blue[15:8] red[23:16] alpha[31:24] count_channel[33:32] count_index[41:34]
  input  logic [rgbapr_pkg::S_TDATA_W-1:0] s_tdata,
  // cmd[0] frame_start[1]
  input  logic [rgbapr_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // res_green[7:0] res_blue[15:8] res_red[23:16] res_alpha[31:24] count_value[63:32]
  output logic [rgbapr_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rgbapr_pkg::PADDR_W-1:0]   paddr,
  input  logic [rgbapr_pkg::PDATA_W-1:0]   pwdata,
  output logic [rgbapr_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready
);
  import rgbapr_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W = (COL_W + 1 > ROW_WIDTH_W) ? COL_W + 1 : ROW_WIDTH_W;

  // Configuration
  logic                   gradient_mode;
  logic [ROW_WIDTH_W-1:0] row_width;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gradient_mode <= 1'b0;
      row_width     <= ROW_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_GRADIENT) begin
        gradient_mode <= pwdata[0];
      end else begin
        row_width <= pwdata[ROW_WIDTH_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_ROW_WIDTH) begin
      prdata = {{(PDATA_W-ROW_WIDTH_W){1'b0}}, row_width};
    end else begin
      prdata = {{(PDATA_W-1){1'b0}}, gradient_mode};
    end
  end

  // Histogram clearing pass
  logic [CLR_CNT_W-1:0] clr_cnt;
  logic                 clearing;

  assign clearing = !clr_cnt[CLR_CNT_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + CLR_CNT_W'(1);
    end
  end

  // Output FIFO
  out_item_t             fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_ptr;
  logic [FIFO_AW-1:0]    rd_ptr;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic [FIFO_CNT_W-1:0] fifo_cnt_next;
  logic                  pop;

  // Pipeline registers
  logic       b_valid;
  logic       c_valid;
  logic       accept;
  logic       pix_acc;

  assign accept   = s_tvalid && s_tready;
  assign pix_acc  = accept && (s_tuser[0] == CMD_PIXEL);
  assign s_tready = !clearing &&
                    ((fifo_cnt + FIFO_CNT_W'(b_valid) + FIFO_CNT_W'(c_valid)) <
                     FIFO_CNT_W'(FIFO_DEPTH));

  // Stage A: column tracking and line store access
  logic [COL_W-1:0] column;
  logic             on_top_row;
  logic [COL_W-1:0] col_cur;
  logic             top_cur;
  logic [CMP_W-1:0] col_inc;
  logic [CMP_W-1:0] rw_ext;
  logic [CMP_W-1:0] eff_w;
  logic             row_end;
  logic [31:0]      row_mem [MAX_WIDTH];
  logic [31:0]      up_rd;

  always_comb begin
    col_cur = s_tuser[1] ? '0 : column;
    top_cur = s_tuser[1] || on_top_row;
    col_inc = CMP_W'(col_cur) + CMP_W'(1);
    rw_ext  = CMP_W'(row_width);
    if (rw_ext == '0) begin
      eff_w = CMP_W'(1);
    end else if (rw_ext > CMP_W'(MAX_WIDTH)) begin
      eff_w = CMP_W'(MAX_WIDTH);
    end else begin
      eff_w = rw_ext;
    end
    row_end = (col_inc >= eff_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column     <= '0;
      on_top_row <= 1'b1;
    end else if (pix_acc) begin
      column     <= row_end ? '0 : col_inc[COL_W-1:0];
      on_top_row <= row_end ? 1'b0 : top_cur;
    end
  end

  // Read the pixel above and store this one in the same slot
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      up_rd           <= row_mem[col_cur];
      row_mem[col_cur] <= s_tdata[31:0];
    end
  end

  logic       b_cmd;
  logic       b_frame;
  logic       b_clr;
  logic       b_use_up;
  logic [7:0] b_g;
  logic [7:0] b_b;
  logic [7:0] b_r;
  logic [7:0] b_a;
  logic [1:0] b_chan;
  logic [7:0] b_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_cmd    <= s_tuser[0];
      b_frame  <= s_tuser[1];
      b_clr    <= !s_tuser[1] && (column == '0) && !on_top_row && gradient_mode;
      b_use_up <= gradient_mode && !top_cur;
      b_g      <= s_tdata[7:0];
      b_b      <= s_tdata[15:8];
      b_r      <= s_tdata[23:16];
      b_a      <= s_tdata[31:24];
      b_chan   <= s_tdata[33:32];
      b_idx    <= s_tdata[41:34];
    end
  end

  // Stage B: residuals and histogram read
  logic [7:0] prev_green;
  logic [7:0] prev_blue;
  logic [7:0] prev_red;
  logic [7:0] prev_alpha;
  logic [7:0] up_g;
  logic [7:0] up_b;
  logic [7:0] up_r;
  logic [7:0] up_a;
  logic [7:0] gg;
  logic [7:0] bb;
  logic [7:0] rr;
  logic [7:0] aa;
  logic [7:0] pg;
  logic [7:0] pb;
  logic [7:0] pr;
  logic [7:0] pa;
  logic [7:0] res  [NUM_CHAN];
  logic [7:0] raddr [NUM_CHAN];

  always_comb begin
    up_g = b_use_up ? up_rd[7:0]   : 8'd0;
    up_b = b_use_up ? up_rd[15:8]  : 8'd0;
    up_r = b_use_up ? up_rd[23:16] : 8'd0;
    up_a = b_use_up ? up_rd[31:24] : 8'd0;
    gg   = b_g - up_g;
    bb   = b_b - up_b - gg;
    rr   = b_r - up_r - gg;
    aa   = b_a - up_a;
    if (b_frame) begin
      pg = PREV_GREEN_INIT;
      pb = 8'd0;
      pr = 8'd0;
      pa = PREV_ALPHA_INIT;
    end else if (b_clr) begin
      pg = 8'd0;
      pb = 8'd0;
      pr = 8'd0;
      pa = 8'd0;
    end else begin
      pg = prev_green;
      pb = prev_blue;
      pr = prev_red;
      pa = prev_alpha;
    end
    res[0] = gg - pg;
    res[1] = bb - pb;
    res[2] = rr - pr;
    res[3] = aa - pa;
    for (int k = 0; k < NUM_CHAN; k++) begin
      raddr[k] = (b_cmd == CMD_READ) ? b_idx : res[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_green <= PREV_GREEN_INIT;
      prev_blue  <= 8'd0;
      prev_red   <= 8'd0;
      prev_alpha <= PREV_ALPHA_INIT;
    end else if (b_valid && (b_cmd == CMD_PIXEL)) begin
      prev_green <= gg;
      prev_blue  <= bb;
      prev_red   <= rr;
      prev_alpha <= aa;
    end
  end

  logic       c_cmd;
  logic [1:0] c_chan;
  logic [7:0] c_addr [NUM_CHAN];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      c_cmd  <= b_cmd;
      c_chan <= b_chan;
      for (int k = 0; k < NUM_CHAN; k++) begin
        c_addr[k] <= raddr[k];
      end
    end
  end

  // Histogram memories, one per channel
  logic [NUM_CHAN-1:0] hist_we;
  logic [7:0]          hist_waddr [NUM_CHAN];
  logic [31:0]         hist_wdata [NUM_CHAN];
  logic [31:0]         hist_rd    [NUM_CHAN];

  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_hist
    logic [31:0] mem [HIST_BINS];
    logic [31:0] rd;

    always_ff @(posedge clk) begin
      if (hist_we[k]) begin
        mem[hist_waddr[k]] <= hist_wdata[k];
      end
      if (b_valid) begin
        rd <= mem[raddr[k]];
      end
    end

    assign hist_rd[k] = rd;
  end

  // Stage C: write-back with forwarding of the previous cycle's write
  logic [NUM_CHAN-1:0] last_we;
  logic [7:0]          last_addr [NUM_CHAN];
  logic [31:0]         last_data [NUM_CHAN];
  logic [NUM_CHAN-1:0] item_we;
  logic [31:0]         item_wdata [NUM_CHAN];
  logic [31:0]         base [NUM_CHAN];
  out_item_t           out_item;

  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      base[k] = (last_we[k] && (last_addr[k] == c_addr[k])) ? last_data[k] : hist_rd[k];
      item_we[k] = c_valid && ((c_cmd == CMD_PIXEL) || (c_chan == 2'(k)));
      item_wdata[k] = (c_cmd == CMD_READ) ? 32'd0 : base[k] + 32'd1;
      hist_we[k]    = clearing || item_we[k];
      hist_waddr[k] = clearing ? clr_cnt[7:0] : c_addr[k];
      hist_wdata[k] = clearing ? 32'd0 : item_wdata[k];
    end
    if (c_cmd == CMD_READ) begin
      out_item.count_value = base[c_chan];
      out_item.res_green   = 8'd0;
      out_item.res_blue    = 8'd0;
      out_item.res_red     = 8'd0;
      out_item.res_alpha   = 8'd0;
    end else begin
      out_item.count_value = 32'd0;
      out_item.res_green   = c_addr[0];
      out_item.res_blue    = c_addr[1];
      out_item.res_red     = c_addr[2];
      out_item.res_alpha   = c_addr[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_we <= '0;
    end else begin
      last_we <= item_we;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      last_addr[k] <= c_addr[k];
      last_data[k] <= item_wdata[k];
    end
  end

  // Output FIFO
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (fifo_cnt != '0);
  assign m_tdata  = fifo_mem[rd_ptr];

  always_comb begin
    fifo_cnt_next = fifo_cnt + FIFO_CNT_W'(c_valid) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (c_valid) begin
      fifo_mem[wr_ptr] <= out_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (c_valid) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_cnt <= fifo_cnt_next;
    end
  end

endmodule

FILE: sv/rgbapr_check.sv
// Port-level checker for the RGBA residual predictor, bound to the top level.
`timescale 1ns / 1ps

module rgbapr_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [rgbapr_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                             m_tvalid,
  input logic                             m_tready
);
  import rgbapr_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

  // A count read carries zero residuals
  a_count_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[63:32] != 32'd0) |-> (m_tdata[31:0] == 32'd0))
    else $error("count result with nonzero residuals");

  // Histogram clearing pass blocks input right after reset
  a_clear_block: assert property (@(posedge clk)
    $past(rst) && !rst |-> !s_tready)
    else $error("input taken during clearing pass");

  // Every transfer shows up at the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> ##3 m_tvalid)
    else $error("result missing after transfer");

endmodule

bind rgba_predict_residual_count rgbapr_check u_rgbapr_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
